// ===== rtl/dbsl_pkg.sv =====
// Package for the decaying bar segment layout block.
// Holds the shared types, register codes and fixed-point constants; no dependencies.
package dbsl_pkg;

	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int POS_W       = 13;
	localparam int SPAN_W      = 12;
	localparam int LEVEL_W     = 17;
	localparam int WORD_W      = 32;
	localparam int PROD_W      = 49;
	localparam int STEP_W      = 5;
	localparam int SHIFT_W     = 16;
	localparam int BARW_W      = 14;

	localparam logic [STEP_W-1:0]  FRAC_STEPS = 5'd16;
	localparam logic [STEP_W-1:0]  BAR_STEPS  = 5'd13;
	localparam logic [LEVEL_W-1:0] Q_ONE      = 17'd65536;
	localparam logic [PROD_W-1:0]  Q_HALF     = 49'd32768;
	localparam logic [BARW_W-1:0]  BARW_SAT   = 14'd8191;

	localparam logic [11:0] ORIGIN_RST = 12'd0;
	localparam logic [11:0] LENGTH_RST = 12'd100;
	localparam logic [15:0] ALPHA_RST  = 16'd63570;

	typedef enum logic [1:0] {
		REG_ORIGIN = 2'd0,
		REG_LENGTH = 2'd1,
		REG_ALPHA  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] origin;
		logic [11:0] length;
		logic [15:0] alpha;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [STEP_W-1:0]   steps;
		logic [WORD_W-1:0]   divisor;
		logic [WORD_W-1:0]   rem_init;
		logic [SHIFT_W-1:0]  low_bits;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [LEVEL_W-1:0]  quo;
	} div_rsp_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] avg;
		logic [LEVEL_W-1:0] prev_avg;
		logic [POS_W-1:0]   prev_span;
		logic [POS_W-1:0]   prev_start;
	} fld_ent_t;

endpackage

// ===== rtl/dbsl_regs.sv =====
// Configuration registers of the bar layout block behind a small APB-style port.
// Depends on dbsl_pkg for the register codes, reset values and the cfg_t bundle.
module dbsl_regs import dbsl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin <= ORIGIN_RST;
			cfg_q.length <= LENGTH_RST;
			cfg_q.alpha  <= ALPHA_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ORIGIN: begin
					cfg_q.origin <= pwdata[11:0];
				end
				REG_LENGTH: begin
					cfg_q.length <= pwdata[11:0];
				end
				REG_ALPHA: begin
					cfg_q.alpha <= pwdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORIGIN: prdata = PDATA_W'(cfg_q.origin);
			REG_LENGTH: prdata = PDATA_W'(cfg_q.length);
			REG_ALPHA:  prdata = PDATA_W'(cfg_q.alpha);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/dbsl_div.sv =====
// Shared restoring divider, one quotient bit per cycle plus a final rounding step.
// Depends on dbsl_pkg for the request and response bundles.
module dbsl_div import dbsl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [WORD_W-1:0]  rem_q;
	logic [WORD_W-1:0]  dvs_q;
	logic [SHIFT_W-1:0] sh_q;
	logic [LEVEL_W-1:0] quo_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;
	logic               shin;
	logic [WORD_W:0]    cat;
	logic [WORD_W:0]    diff;
	logic               ge;

	// The remainder always stays below the divisor, so a kept partial fits the word.
	assign shin = (cnt_q != '0) ? sh_q[SHIFT_W-1] : 1'b0;
	assign cat  = {rem_q, shin};
	assign ge   = (cat >= {1'b0, dvs_q});
	assign diff = cat - {1'b0, dvs_q};

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvs_q <= req.divisor;
			sh_q  <= req.low_bits;
			quo_q <= '0;
		end else if (run_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? diff[WORD_W-1:0] : cat[WORD_W-1:0];
				sh_q  <= {sh_q[SHIFT_W-2:0], 1'b0};
				quo_q <= {quo_q[LEVEL_W-2:0], ge};
			end else begin
				quo_q <= quo_q + LEVEL_W'(ge);
			end
		end
	end

endmodule

// ===== rtl/decaying_bar_segment_layout.sv =====
// Decaying segmented bar layout: one field per request, two bar segments per result.
// A request with a nonzero total is worked through by the shared divider (fraction, then bar
// width; each division is skipped when saturated), then the average update and output register.
// One request is taken at a time: the next is accepted only after the last result is registered.
// Reset is asynchronous and active low; it loads the register defaults and marks every
// per-field entry as zero. Depends on dbsl_pkg, dbsl_regs and dbsl_div.
module decaying_bar_segment_layout import dbsl_pkg::*; #(
	parameter int MAX_FIELDS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        field_value,
	input  logic [31:0]        sample_total,
	input  logic               force_redraw,
	input  logic               last_field,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         field_index,
	output logic [12:0]        bar_start,
	output logic [11:0]        bar_span,
	output logic [12:0]        avg_start,
	output logic [11:0]        avg_span,
	output logic [16:0]        avg_level,
	output logic               draw_bar,
	output logic               draw_avg,
	output logic               end_of_sample
);

	localparam int SLOT_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_FIELDS - 1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'h001,
		S_MULV  = 11'h002,
		S_FWAIT = 11'h004,
		S_BDIV  = 11'h008,
		S_BWAIT = 11'h010,
		S_MA    = 11'h020,
		S_MB    = 11'h040,
		S_MC    = 11'h080,
		S_MW    = 11'h100,
		S_FIN   = 11'h200,
		S_SPARE = 11'h400
	} state_t;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;
	state_t   state_q;

	logic               busy_q;
	logic               seeding_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  s_q;
	logic [POS_W-1:0]   cur_pos_q;
	logic [POS_W-1:0]   avg_pos_q;
	logic [POS_W-1:0]   x_q;
	logic [POS_W-1:0]   dx_q;
	logic               out_valid_q;
	logic [MAX_FIELDS-1:0] vld_q;

	logic [WORD_W-1:0]  val_q;
	logic [WORD_W-1:0]  tot_q;
	logic               frc_q;
	logic               last_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LEVEL_W-1:0] frac_q;
	logic [BARW_W-1:0]  bw_q;
	logic [LEVEL_W-1:0] avg_q;

	fld_ent_t           mem [MAX_FIELDS];
	fld_ent_t           rd_q;
	logic               rd_vld_q;
	fld_ent_t           ent;
	fld_ent_t           ent_new;

	logic [2:0]         idx_q;
	logic [POS_W-1:0]   bar_start_q;
	logic [SPAN_W-1:0]  bar_span_q;
	logic [POS_W-1:0]   avg_start_q;
	logic [SPAN_W-1:0]  avg_span_q;
	logic [LEVEL_W-1:0] avg_lvl_q;
	logic               draw_bar_q;
	logic               draw_avg_q;
	logic               eos_q;

	logic               in_acc;
	logic               out_free;
	logic               fin_go;
	logic               v_ge_t;
	logic               bsat;
	logic [LEVEL_W-1:0] mul_a;
	logic [WORD_W-1:0]  mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [LEVEL_W-1:0] old_avg;
	logic [PROD_W-1:0]  rnd_sum;
	logic [LEVEL_W-1:0] avg_rnd;
	logic [POS_W-1:0]   end_pos;
	logic [POS_W-1:0]   room_b;
	logic [POS_W-1:0]   room_a;
	logic [POS_W-1:0]   tw;
	logic [POS_W-1:0]   dw_raw;
	logic [POS_W-1:0]   dw;
	logic               dbar;
	logic               davg;
	logic [SLOT_W+2:0]  s_ext;

	dbsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbsl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign fin_go   = (state_q == S_FIN) && out_free;
	assign v_ge_t   = (val_q >= tot_q);
	assign bsat     = ({1'b0, prod_q[43:13]} >= tot_q);

	always_comb begin
		div_req.start    = ((state_q == S_MULV) && !v_ge_t) || ((state_q == S_BDIV) && !bsat);
		div_req.divisor  = tot_q;
		if (state_q == S_MULV) begin
			div_req.steps    = FRAC_STEPS;
			div_req.rem_init = val_q;
			div_req.low_bits = '0;
		end else begin
			div_req.steps    = BAR_STEPS;
			div_req.rem_init = {1'b0, prod_q[43:13]};
			div_req.low_bits = {prod_q[12:0], 3'b000};
		end
	end

	assign ent     = rd_vld_q ? rd_q : '0;
	assign old_avg = seeding_q ? frac_q : ent.avg;

	always_comb begin
		case (state_q)
			S_MULV: begin
				mul_a = LEVEL_W'(cfg.length);
				mul_b = val_q;
			end
			S_MA: begin
				mul_a = old_avg;
				mul_b = WORD_W'(cfg.alpha);
			end
			S_MB: begin
				mul_a = Q_ONE - LEVEL_W'(cfg.alpha);
				mul_b = WORD_W'(frac_q);
			end
			S_MW: begin
				mul_a = LEVEL_W'(cfg.length);
				mul_b = WORD_W'(avg_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign rnd_sum = prod_q + Q_HALF;
	assign avg_rnd = (rnd_sum[PROD_W-1:16] > (PROD_W-16)'(Q_ONE)) ? Q_ONE
	                 : rnd_sum[32:16];

	assign end_pos = POS_W'(cfg.origin) + POS_W'(cfg.length);
	assign room_b  = (end_pos > x_q) ? end_pos - x_q : '0;
	assign room_a  = (end_pos > dx_q) ? end_pos - dx_q : '0;
	assign tw      = (last_q || (bw_q > BARW_W'(room_b))) ? room_b : bw_q[POS_W-1:0];
	assign dw_raw  = rnd_sum[28:16];
	assign dw      = (last_q || (dw_raw > room_a)) ? room_a : dw_raw;
	assign dbar    = frc_q || (tw != ent.prev_span) || (x_q != ent.prev_start);
	assign davg    = frc_q || (avg_q != ent.prev_avg);
	assign s_ext   = (SLOT_W+3)'(s_q);

	always_comb begin
		ent_new.avg        = avg_q;
		ent_new.prev_avg   = davg ? avg_q : ent.prev_avg;
		ent_new.prev_span  = dbar ? tw : ent.prev_span;
		ent_new.prev_start = dbar ? x_q : ent.prev_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			seeding_q   <= 1'b1;
			slot_q      <= '0;
			s_q         <= '0;
			cur_pos_q   <= '0;
			avg_pos_q   <= '0;
			x_q         <= '0;
			dx_q        <= '0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (sample_total != '0)) begin
						state_q   <= S_MULV;
						busy_q    <= 1'b1;
						x_q       <= busy_q ? cur_pos_q : POS_W'(cfg.origin);
						dx_q      <= busy_q ? avg_pos_q : POS_W'(cfg.origin);
						s_q       <= busy_q ? slot_q : '0;
					end
				end
				S_MULV: begin
					state_q <= v_ge_t ? S_BDIV : S_FWAIT;
				end
				S_FWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_BDIV;
					end
				end
				S_BDIV: begin
					state_q <= bsat ? S_MA : S_BWAIT;
				end
				S_BWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_MA;
					end
				end
				S_MA: begin
					state_q <= S_MB;
				end
				S_MB: begin
					state_q <= S_MC;
				end
				S_MC: begin
					state_q <= S_MW;
				end
				S_MW: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q   <= S_IDLE;
						vld_q[s_q] <= 1'b1;
						if (last_q) begin
							seeding_q <= 1'b0;
							busy_q    <= 1'b0;
							slot_q    <= '0;
							cur_pos_q <= POS_W'(cfg.origin);
							avg_pos_q <= POS_W'(cfg.origin);
						end else begin
							slot_q    <= (s_q < SLOT_MAX) ? s_q + 1'b1 : s_q;
							cur_pos_q <= x_q + tw;
							avg_pos_q <= dx_q + dw;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q  <= field_value;
			tot_q  <= sample_total;
			frc_q  <= force_redraw;
			last_q <= last_field;
		end
		case (state_q)
			S_MULV: begin
				prod_q <= mul_p;
				if (v_ge_t) begin
					frac_q <= Q_ONE;
				end
			end
			S_FWAIT: begin
				if (div_rsp.done) begin
					frac_q <= div_rsp.quo;
				end
			end
			S_BDIV: begin
				if (bsat) begin
					bw_q <= BARW_SAT;
				end
			end
			S_BWAIT: begin
				if (div_rsp.done) begin
					bw_q <= div_rsp.quo[BARW_W-1:0];
				end
			end
			S_MA: begin
				prod_q <= mul_p;
			end
			S_MB: begin
				prod_q <= prod_q + mul_p;
			end
			S_MC: begin
				avg_q <= avg_rnd;
			end
			S_MW: begin
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
		if (fin_go) begin
			idx_q       <= s_ext[2:0];
			bar_start_q <= x_q;
			bar_span_q  <= tw[SPAN_W-1:0];
			avg_start_q <= dx_q;
			avg_span_q  <= dw[SPAN_W-1:0];
			avg_lvl_q   <= avg_q;
			draw_bar_q  <= dbar;
			draw_avg_q  <= davg;
			eos_q       <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			mem[s_q] <= ent_new;
		end
		rd_q     <= mem[s_q];
		rd_vld_q <= vld_q[s_q];
	end

	assign out_valid     = out_valid_q;
	assign field_index   = idx_q;
	assign bar_start     = bar_start_q;
	assign bar_span      = bar_span_q;
	assign avg_start     = avg_start_q;
	assign avg_span      = avg_span_q;
	assign avg_level     = avg_lvl_q;
	assign draw_bar      = draw_bar_q;
	assign draw_avg      = draw_avg_q;
	assign end_of_sample = eos_q;

`ifndef SYNTHESIS
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q)
		else $error("finished request did not reach the output register");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_FWAIT || state_q == S_BWAIT))
		else $error("divider finished outside a wait state");

	a_slot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (slot_q == '0))
		else $error("slot not cleared outside a sample");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (avg_lvl_q <= Q_ONE))
		else $error("average level above one");

	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (sample_total == '0)) |=> (state_q == S_IDLE))
		else $error("request with zero total was processed");
`endif

endmodule

// ===== sim/decaying_bar_segment_layout_test.sv =====
// Self-checking testbench for decaying_bar_segment_layout: directed and random field requests
// are driven over valid/ready, and every result is compared with a built-in layout predictor.
// Depends on dbsl_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module decaying_bar_segment_layout_test;
	import dbsl_pkg::*;

	localparam int FIELD_SLOTS = 8;

	typedef struct {
		logic [31:0] value;
		logic [31:0] total;
		logic        redraw;
		logic        last;
	} field_req_t;

	typedef struct {
		logic [2:0]  field_index;
		logic [12:0] bar_start;
		logic [11:0] bar_span;
		logic [12:0] avg_start;
		logic [11:0] avg_span;
		logic [16:0] avg_level;
		logic        draw_bar;
		logic        draw_avg;
		logic        end_of_sample;
	} segment_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        field_value = '0;
	logic [31:0]        sample_total = '0;
	logic               force_redraw = 1'b0;
	logic               last_field = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         field_index;
	logic [12:0]        bar_start;
	logic [11:0]        bar_span;
	logic [12:0]        avg_start;
	logic [11:0]        avg_span;
	logic [16:0]        avg_level;
	logic               draw_bar;
	logic               draw_avg;
	logic               end_of_sample;

	decaying_bar_segment_layout i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.field_value  (field_value),
		.sample_total (sample_total),
		.force_redraw (force_redraw),
		.last_field   (last_field),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.field_index  (field_index),
		.bar_start    (bar_start),
		.bar_span     (bar_span),
		.avg_start    (avg_start),
		.avg_span     (avg_span),
		.avg_level    (avg_level),
		.draw_bar     (draw_bar),
		.draw_avg     (draw_avg),
		.end_of_sample(end_of_sample)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	field_req_t field_q[$];
	segment_t   layout_q[$];
	int         mismatch_count = 0;
	bit         calm = 1'b0;
	bit         req_taken = 1'b0;
	int         gap_left = 0;
	int         stall_left = 0;

	logic [11:0] cfg_origin = ORIGIN_RST;
	logic [11:0] cfg_length = LENGTH_RST;
	logic [15:0] cfg_alpha = ALPHA_RST;
	logic [16:0] level_mem[FIELD_SLOTS] = '{default: '0};
	logic [16:0] shown_level[FIELD_SLOTS] = '{default: '0};
	logic [12:0] shown_span[FIELD_SLOTS] = '{default: '0};
	logic [12:0] shown_start[FIELD_SLOTS] = '{default: '0};
	bit          seed_phase = 1'b1;
	bit          in_sample = 1'b0;
	int unsigned slot_no = 0;
	logic [12:0] bar_pos = '0;
	logic [12:0] lvl_pos = '0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input longint unsigned seen,
			input longint unsigned want);
		if (seen != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, seen, want));
	endtask

	task automatic check_segment(input segment_t seen, input segment_t want);
		check_field("field_index", seen.field_index, want.field_index);
		check_field("bar_start", seen.bar_start, want.bar_start);
		check_field("bar_span", seen.bar_span, want.bar_span);
		check_field("avg_start", seen.avg_start, want.avg_start);
		check_field("avg_span", seen.avg_span, want.avg_span);
		check_field("avg_level", seen.avg_level, want.avg_level);
		check_field("draw_bar", seen.draw_bar, want.draw_bar);
		check_field("draw_avg", seen.draw_avg, want.draw_avg);
		check_field("end_of_sample", seen.end_of_sample, want.end_of_sample);
	endtask

	function automatic longint unsigned fit_span(input longint unsigned pos,
			input longint unsigned bar_end, input longint unsigned want, input bit last);
		longint unsigned room;
		room = (bar_end > pos) ? bar_end - pos : 0;
		return (last || want > room) ? room : want;
	endfunction

	// Advances the layout state by one field; returns 0 when the field gives no result.
	function automatic bit layout_field(input field_req_t rq, output segment_t sg);
		longint unsigned v, t, frac, lvl, bar_end, tw, dw, x, dx;
		int unsigned s;
		bit dbar, davg;
		sg = '{default: '0};
		if (rq.total == 0)
			return 1'b0;
		if (!in_sample) begin
			bar_pos = 13'(cfg_origin);
			lvl_pos = 13'(cfg_origin);
			slot_no = 0;
			in_sample = 1'b1;
		end
		s = (slot_no < FIELD_SLOTS) ? slot_no : FIELD_SLOTS - 1;
		v = rq.value;
		t = rq.total;
		x = bar_pos;
		dx = lvl_pos;
		bar_end = longint'(cfg_origin) + longint'(cfg_length);
		frac = ((v << 16) + t / 2) / t;
		if (frac > 65536)
			frac = 65536;
		if (seed_phase)
			level_mem[s] = 17'(frac);
		lvl = (longint'(cfg_alpha) * level_mem[s] + (65536 - longint'(cfg_alpha)) * frac
			+ 32768) >> 16;
		if (lvl > 65536)
			lvl = 65536;
		level_mem[s] = 17'(lvl);
		tw = fit_span(x, bar_end, (2 * longint'(cfg_length) * v + t) / (2 * t), rq.last);
		dw = fit_span(dx, bar_end, (longint'(cfg_length) * lvl + 32768) >> 16, rq.last);
		dbar = rq.redraw || tw != shown_span[s] || x != shown_start[s];
		if (dbar) begin
			shown_span[s] = 13'(tw);
			shown_start[s] = 13'(x);
		end
		davg = rq.redraw || lvl != shown_level[s];
		if (davg)
			shown_level[s] = 17'(lvl);
		sg.field_index = 3'(s);
		sg.bar_start = 13'(x);
		sg.bar_span = 12'(tw);
		sg.avg_start = 13'(dx);
		sg.avg_span = 12'(dw);
		sg.avg_level = 17'(lvl);
		sg.draw_bar = dbar;
		sg.draw_avg = davg;
		sg.end_of_sample = rq.last;
		bar_pos = 13'(x + tw);
		lvl_pos = 13'(dx + dw);
		if (slot_no < FIELD_SLOTS - 1)
			slot_no++;
		if (rq.last) begin
			seed_phase = 1'b0;
			in_sample = 1'b0;
			slot_no = 0;
			bar_pos = 13'(cfg_origin);
			lvl_pos = 13'(cfg_origin);
		end
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(5, 90);
	endfunction

	always @(negedge clk) begin
		field_req_t rq;
		if (arst_n && (!in_valid || req_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (field_q.size() != 0) begin
				rq = field_q.pop_front();
				in_valid <= 1'b1;
				field_value <= rq.value;
				sample_total <= rq.total;
				force_redraw <= rq.redraw;
				last_field <= rq.last;
				gap_left <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 7) == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		segment_t seen, want;
		field_req_t rq;
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				seen = '{field_index, bar_start, bar_span, avg_start, avg_span, avg_level,
					draw_bar, draw_avg, end_of_sample};
				if (layout_q.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = layout_q.pop_front();
					check_segment(seen, want);
				end
			end
			if (in_valid && in_ready) begin
				rq = '{field_value, sample_total, force_redraw, last_field};
				if (layout_field(rq, want))
					layout_q.push_back(want);
			end
		end else begin
			req_taken <= 1'b0;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		mask = (idx == REG_ALPHA) ? 32'h0000_FFFF : 32'h0000_0FFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) != (value & mask))
			report_mismatch($sformatf("register %s read %0d, expected %0d", idx.name(),
				prdata & mask, value & mask));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ORIGIN: cfg_origin = value[11:0];
			REG_LENGTH: cfg_length = value[11:0];
			REG_ALPHA:  cfg_alpha = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int origin, input int length, input int alpha);
		write_reg(REG_ORIGIN, origin);
		write_reg(REG_LENGTH, length);
		write_reg(REG_ALPHA, alpha);
	endtask

	task automatic queue_field(input logic [31:0] value, input logic [31:0] total,
			input logic redraw, input logic last);
		field_q.push_back('{value, total, redraw, last});
	endtask

	// Zero-total requests give no result, so some slack follows the last expected result.
	task automatic wait_idle();
		while (field_q.size() != 0 || in_valid || layout_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic fill_phase(input int target);
		logic [31:0] vals[12];
		logic [31:0] total, t;
		longint unsigned sum;
		int taken, n, cls, k, r;
		taken = 0;
		n = 0;
		while (taken < target) begin
			if ($urandom_range(0, 99) < 82) begin
				// Reusing the previous sample lets averages settle and redraw flags drop.
				if (n == 0 || $urandom_range(0, 2) != 0) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
					cls = $urandom_range(0, 2);
					sum = 0;
					for (k = 0; k < n; k++) begin
						case (cls)
							0: vals[k] = $urandom_range(0, 20);
							1: vals[k] = $urandom_range(0, 65535);
							default: vals[k] = $urandom() / n;
						endcase
						sum += vals[k];
					end
					total = sum[31:0];
				end
				for (k = 0; k < n; k++)
					queue_field(vals[k], total, $urandom_range(0, 15) == 0, k == n - 1);
				if (total != 0)
					taken += n;
			end else begin
				r = $urandom_range(0, 99);
				t = (r < 30) ? 32'd0 : (r < 60) ? $urandom() : $urandom_range(1, 50);
				queue_field($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 60), t,
					$urandom_range(0, 1), $urandom_range(0, 1));
				if (t != 0)
					taken++;
			end
		end
	endtask

	initial begin
		int ph, k;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_field(0, 3, 1'b0, 1'b0);
		queue_field(1, 3, 1'b0, 1'b0);
		queue_field(2, 3, 1'b0, 1'b1);
		queue_field(7, 0, 1'b1, 1'b1);
		queue_field(10, 3, 1'b0, 1'b0);
		queue_field(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		for (k = 0; k < 10; k++)
			queue_field(1, 10, 1'b0, k == 9);
		repeat (2) begin
			queue_field(1, 2, 1'b0, 1'b0);
			queue_field(1, 2, 1'b0, 1'b1);
		end
		queue_field(1, 2, 1'b1, 1'b0);
		queue_field(1, 2, 1'b1, 1'b1);
		queue_field(1, 2, 1'b0, 1'b0);
		wait_idle();
		// Shrinking the bar inside a sample puts the next segment past the bar end.
		write_reg(REG_LENGTH, 20);
		queue_field(1, 2, 1'b0, 1'b1);
		wait_idle();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(4095, 4095, 65535);
				1: set_config(0, 1, 0);
				2: set_config(100, 4095, 1);
				3: set_config(ORIGIN_RST, LENGTH_RST, ALPHA_RST);
				default: set_config($urandom_range(0, 4095), $urandom_range(1, 4095),
					$urandom_range(0, 65535));
			endcase
			calm = ($urandom_range(0, 3) == 0);
			fill_phase(88);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", layout_q.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dbsl_pkg.sv
rtl/dbsl_regs.sv
rtl/dbsl_div.sv
rtl/decaying_bar_segment_layout.sv
sim/decaying_bar_segment_layout_test.sv
